// ----- design/plc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and constants for the tone curve unit
// no dependencies; imported by every module of the block

package plc_pkg;

    localparam int DEF_MAX_KNOTS = 8;
    localparam int PIX_W         = 8;
    localparam int KNOT_BUS_W    = 64;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int PROD_W        = 2 * PIX_W;
    localparam int MIN_KNOTS     = 2;

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = PIX_W / DIV_BITS_PER_STAGE;
    // select, multiply, divider stages, output register
    localparam int NUM_STAGES         = DIV_STAGES + 3;

    localparam logic [PIX_W-1:0]      PIX_MAX         = 8'hFF;
    localparam logic [CNT_W-1:0]      RST_KNOT_COUNT  = 4'd2;
    localparam logic [KNOT_BUS_W-1:0] RST_KNOT_X      = 64'h0000_0000_0000_FF00;
    localparam logic [KNOT_BUS_W-1:0] RST_KNOT_Y      = 64'h0000_0000_0000_FF00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNOT_COUNT = 2'd0,
        REG_KNOT_X     = 2'd1,
        REG_KNOT_Y     = 2'd2
    } cfg_reg_t;

    // segment chosen for one item: y = y1 +/- (a * dy_mag) / dx
    typedef struct packed {
        logic [PIX_W-1:0] y1;
        logic             neg;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] dy_mag;
        logic [PIX_W-1:0] dx;
    } seg_t;

    // divider working word: remainder in the upper half, quotient shifts in below
    typedef struct packed {
        logic [PIX_W-1:0]  y1;
        logic              neg;
        logic [PROD_W-1:0] w;
        logic [PIX_W-1:0]  dx;
    } quo_t;

    // one restoring division step
    function automatic logic [PROD_W-1:0] div_step(
        input logic [PROD_W-1:0] w,
        input logic [PIX_W-1:0]  d
    );
        logic [PROD_W:0] t;
        t = {w, 1'b0};
        if (t[PROD_W:PIX_W] >= {1'b0, d})
        begin
            t[PROD_W:PIX_W] = t[PROD_W:PIX_W] - {1'b0, d};
            t[0] = 1'b1;
        end
        return t[PROD_W-1:0];
    endfunction

endpackage

// ----- design/plc_select.sv -----
`timescale 1ns / 1ps
// knot search stage: finds the segment holding the pixel and registers it
// depends on plc_pkg

module plc_select
    import plc_pkg::*;
#(
    parameter int MAX_KNOTS = DEF_MAX_KNOTS
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [PIX_W-1:0]      pixel,
    input  logic [CNT_W-1:0]      knot_count,
    input  logic [KNOT_BUS_W-1:0] knot_x,
    input  logic [KNOT_BUS_W-1:0] knot_y,
    output seg_t                  seg
);

    localparam int IDX_W = $clog2(MAX_KNOTS);

    logic [PIX_W-1:0]     kx [MAX_KNOTS];
    logic [PIX_W-1:0]     ky [MAX_KNOTS];
    logic [CNT_W-1:0]     n_used;
    logic [CNT_W-1:0]     last_full;
    logic [IDX_W-1:0]     last_idx;
    logic [MAX_KNOTS-2:0] hit;
    logic [IDX_W-1:0]     sel;
    logic                 found;
    logic [PIX_W-1:0]     x1;
    logic [PIX_W-1:0]     x2;
    logic [PIX_W-1:0]     y2;
    seg_t                 seg_next;
    seg_t                 seg_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_KNOTS; i++)
        begin
            kx[i] = knot_x[i*PIX_W +: PIX_W];
            ky[i] = knot_y[i*PIX_W +: PIX_W];
        end
    end

    always_comb
    begin
        n_used = knot_count;
        if (n_used < CNT_W'(MIN_KNOTS))
        begin
            n_used = CNT_W'(MIN_KNOTS);
        end
        if (n_used > CNT_W'(MAX_KNOTS))
        begin
            n_used = CNT_W'(MAX_KNOTS);
        end
        last_full = n_used - CNT_W'(1);
        last_idx  = last_full[IDX_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KNOTS - 1; i++)
        begin
            hit[i] = (CNT_W'(i) < last_full) && (pixel >= kx[i]) && (pixel <= kx[i+1]);
        end
        sel   = '0;
        found = 1'b0;
        // lowest matching segment wins
        for (int i = MAX_KNOTS - 2; i >= 0; i--)
        begin
            if (hit[i])
            begin
                sel   = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        x1 = kx[sel];
        x2 = kx[sel + IDX_W'(1)];
        y2 = ky[sel + IDX_W'(1)];
        seg_next.y1     = '0;
        seg_next.neg    = 1'b0;
        seg_next.a      = '0;
        seg_next.dy_mag = '0;
        seg_next.dx     = PIX_W'(1);
        if (pixel <= kx[0])
        begin
            seg_next.y1 = ky[0];
        end
        else if (pixel >= kx[last_idx])
        begin
            seg_next.y1 = ky[last_idx];
        end
        else if (found)
        begin
            seg_next.y1  = ky[sel];
            seg_next.neg = y2 < ky[sel];
            seg_next.dy_mag = seg_next.neg ? (ky[sel] - y2) : (y2 - ky[sel]);
            // zero-width segment keeps a = 0 and divides by one
            if (x2 != x1)
            begin
                seg_next.dx = x2 - x1;
                seg_next.a  = pixel - x1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg = seg_reg;

endmodule

// ----- design/plc_mul.sv -----
`timescale 1ns / 1ps
// multiply stage: offset times slope magnitude, registered
// depends on plc_pkg

module plc_mul
    import plc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  seg_t seg,
    output quo_t quo
);

    quo_t quo_next;
    quo_t quo_reg;

    always_comb
    begin
        quo_next.y1  = seg.y1;
        quo_next.neg = seg.neg;
        quo_next.w   = PROD_W'(seg.a) * PROD_W'(seg.dy_mag);
        quo_next.dx  = seg.dx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- design/plc_div_stage.sv -----
`timescale 1ns / 1ps
// one stage of the pipelined restoring divider, two quotient bits per stage
// depends on plc_pkg (div_step)

module plc_div_stage
    import plc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  quo_t din,
    output quo_t dout
);

    quo_t dout_next;
    quo_t dout_reg;

    always_comb
    begin
        dout_next = din;
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++)
        begin
            dout_next.w = div_step(dout_next.w, din.dx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- design/piecewise_linear_tone_curve_unit.sv -----
`timescale 1ns / 1ps
// top level of the piecewise linear tone curve: config registers, stage control, output
// depends on plc_pkg, plc_select, plc_mul, plc_div_stage
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------
//   in       | in_valid / in_stall | pixel_in [7:0]
//   out      | out_valid/out_stall | pixel_out [7:0]
//   config   | cfg_wr_en           | cfg_index [1:0], cfg_wdata [63:0]
//
// one item per cycle sustained while out_stall is low; stages are search, multiply, four
// divider stages of two quotient bits each, output register
// rst_n clears the stage valid bits and loads the identity curve
// a stalled output holds its item; empty stages upstream still fill, so
// in_stall rises only once every stage holds an item

module piecewise_linear_tone_curve_unit
    import plc_pkg::*;
#(
    parameter int MAX_KNOTS = DEF_MAX_KNOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0]      knot_count_reg;
    logic [KNOT_BUS_W-1:0] knot_x_reg;
    logic [KNOT_BUS_W-1:0] knot_y_reg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    seg_t                  seg_s;
    quo_t                  quo_s [DIV_STAGES+1];

    logic [PIX_W-1:0]      quot;
    logic signed [PIX_W+1:0] ysum;
    logic [PIX_W-1:0]      pixel_out_next;
    logic [PIX_W-1:0]      pixel_out_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= RST_KNOT_COUNT;
            knot_x_reg     <= RST_KNOT_X;
            knot_y_reg     <= RST_KNOT_Y;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KNOT_COUNT: knot_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_KNOT_X:     knot_x_reg     <= cfg_wdata[KNOT_BUS_W-1:0];
                REG_KNOT_Y:     knot_y_reg     <= cfg_wdata[KNOT_BUS_W-1:0];
                default:        ;
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    plc_select #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_select (
        .clk        (clk),
        .en         (adv[0]),
        .pixel      (pixel_in),
        .knot_count (knot_count_reg),
        .knot_x     (knot_x_reg),
        .knot_y     (knot_y_reg),
        .seg        (seg_s)
    );

    plc_mul u_mul (
        .clk (clk),
        .en  (adv[1]),
        .seg (seg_s),
        .quo (quo_s[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        plc_div_stage u_div (
            .clk  (clk),
            .en   (adv[g+2]),
            .din  (quo_s[g]),
            .dout (quo_s[g+1])
        );
    end

    // apply signed offset and clamp
    always_comb
    begin
        quot = quo_s[DIV_STAGES].w[PIX_W-1:0];
        if (quo_s[DIV_STAGES].neg)
        begin
            ysum = signed'({2'b00, quo_s[DIV_STAGES].y1}) - signed'({2'b00, quot});
        end
        else
        begin
            ysum = signed'({2'b00, quo_s[DIV_STAGES].y1}) + signed'({2'b00, quot});
        end
        if (ysum < 0)
        begin
            pixel_out_next = '0;
        end
        else if (ysum > signed'({2'b00, PIX_MAX}))
        begin
            pixel_out_next = PIX_MAX;
        end
        else
        begin
            pixel_out_next = ysum[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            pixel_out_reg <= pixel_out_next;
        end
    end

    assign pixel_out = pixel_out_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> !in_stall)
        else $error("empty pipeline stalls input");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && out_stall) |-> in_stall)
        else $error("full pipeline accepts item under output stall");

    a_seg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (seg_s.dx != '0) && (seg_s.a <= seg_s.dx))
        else $error("segment offset exceeds its width");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES-2] |->
            (quo_s[DIV_STAGES].w[PROD_W-1:PIX_W] < quo_s[DIV_STAGES].dx))
        else $error("divider remainder not below divisor");
`endif

endmodule
